### src/frustum_cull_test_defines.svh
`ifndef FRUSTUM_CULL_TEST_DEFINES_SVH
`define FRUSTUM_CULL_TEST_DEFINES_SVH

// clocked check, idle while reset is high
`define FCT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition that must never be seen
`define FCT_ASSERT_NEVER(label, cond, msg) \
   `FCT_ASSERT(label, !(cond), msg)

`endif

### src/fct_pkg.sv
package fct_pkg;

   localparam int PLANE_COUNT    = 6;
   localparam int COORD_BITS     = 16;
   localparam int SLOT_COUNT     = 6;
   localparam int LANE_COUNT     = (PLANE_COUNT < SLOT_COUNT) ? PLANE_COUNT : SLOT_COUNT;

   localparam int RADIUS_BITS    = COORD_BITS - 1;
   localparam int NORM_BITS      = 16;
   localparam int NORM_FRAC_BITS = 14;
   localparam int PROD_BITS      = NORM_BITS + COORD_BITS;
   localparam int WTERM_BITS     = NORM_BITS + NORM_FRAC_BITS;
   localparam int DIST_BITS      = ((PROD_BITS > WTERM_BITS) ? PROD_BITS : WTERM_BITS) + 2;

   localparam int CSR_DATA_BITS  = 64;
   localparam int SLOT_BYTES     = CSR_DATA_BITS / 8;
   localparam int SLOT_LSB       = $clog2(SLOT_BYTES);
   localparam int CSR_ADDR_BITS  = $clog2(SLOT_COUNT * SLOT_BYTES);
   localparam int SLOT_IDX_BITS  = CSR_ADDR_BITS - SLOT_LSB;

   typedef enum logic [1:0] {
      OP_POINT  = 2'd0,
      OP_SPHERE = 2'd1,
      OP_BOX    = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef struct packed {
      logic signed [NORM_BITS-1:0] w;
      logic signed [NORM_BITS-1:0] nz;
      logic signed [NORM_BITS-1:0] ny;
      logic signed [NORM_BITS-1:0] nx;
   } plane_type;

   typedef struct packed {
      op_type                       opcode;
      logic signed [COORD_BITS-1:0] first_x;
      logic signed [COORD_BITS-1:0] first_y;
      logic signed [COORD_BITS-1:0] first_z;
      logic signed [COORD_BITS-1:0] second_x;
      logic signed [COORD_BITS-1:0] second_y;
      logic signed [COORD_BITS-1:0] second_z;
      logic        [RADIUS_BITS-1:0] radius;
   } query_type;

endpackage

### src/fct_csr.sv
module fct_csr (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        psel,
   input  logic                                        penable,
   input  logic                                        pwrite,
   input  logic [fct_pkg::CSR_ADDR_BITS-1:0]           paddr,
   input  logic [fct_pkg::CSR_DATA_BITS-1:0]           pwdata,
   output logic [fct_pkg::CSR_DATA_BITS-1:0]           prdata,
   output logic                                        pready,
   output fct_pkg::plane_type [fct_pkg::SLOT_COUNT-1:0] planes
);

   fct_pkg::plane_type [fct_pkg::SLOT_COUNT-1:0] slot_ff;
   fct_pkg::plane_type [fct_pkg::SLOT_COUNT-1:0] slot_in;
   logic [fct_pkg::SLOT_IDX_BITS-1:0]            slot_idx;
   logic                                         slot_hit;
   logic                                         wr_en;

   assign pready   = 1'b1;
   assign slot_idx = paddr[fct_pkg::CSR_ADDR_BITS-1:fct_pkg::SLOT_LSB];
   assign slot_hit = (slot_idx < fct_pkg::SLOT_IDX_BITS'(fct_pkg::SLOT_COUNT));
   assign wr_en    = psel && penable && pwrite && pready;

   always_comb begin
      for (int i = 0; i < fct_pkg::SLOT_COUNT; i++) begin
         if (wr_en && slot_hit && (slot_idx == fct_pkg::SLOT_IDX_BITS'(i))) begin
            slot_in[i] = fct_pkg::plane_type'(pwdata);
         end else begin
            slot_in[i] = slot_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   always_comb begin
      if (slot_hit) begin
         prdata = fct_pkg::CSR_DATA_BITS'(slot_ff[slot_idx]);
      end else begin
         prdata = '0;
      end
   end

   assign planes = slot_ff;

endmodule

### src/fct_lane.sv
module fct_lane (
   input  logic                clock,
   input  fct_pkg::query_type  query,
   input  fct_pkg::plane_type  plane,
   output logic                cull
);

   logic signed [fct_pkg::COORD_BITS-1:0] corner_x_in, corner_y_in, corner_z_in;
   logic signed [fct_pkg::COORD_BITS-1:0] corner_x_ff, corner_y_ff, corner_z_ff;
   logic signed [fct_pkg::DIST_BITS-1:0]  bias;
   logic signed [fct_pkg::DIST_BITS-1:0]  offset_in, offset_ff, offset2_ff;
   logic signed [fct_pkg::PROD_BITS-1:0]  prod_x_in, prod_y_in, prod_z_in;
   logic signed [fct_pkg::PROD_BITS-1:0]  prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [fct_pkg::DIST_BITS-1:0]  dist_sum;
   logic                                  box;
   logic                                  cull_in, cull_ff;

   // farthest corner along the normal for boxes, the first point otherwise
   assign box = (query.opcode == fct_pkg::OP_BOX);

   always_comb begin
      corner_x_in = (box && !plane.nx[fct_pkg::NORM_BITS-1] && (plane.nx != '0)) ?
                    query.second_x : query.first_x;
      corner_y_in = (box && !plane.ny[fct_pkg::NORM_BITS-1] && (plane.ny != '0)) ?
                    query.second_y : query.first_y;
      corner_z_in = (box && !plane.nz[fct_pkg::NORM_BITS-1] && (plane.nz != '0)) ?
                    query.second_z : query.first_z;
   end

   // point: d + 1 <= 0, sphere: d + r <= 0, box: d <= 0
   always_comb begin
      case (query.opcode)
         fct_pkg::OP_POINT: begin
            bias = fct_pkg::DIST_BITS'(1);
         end
         fct_pkg::OP_SPHERE: begin
            bias = fct_pkg::DIST_BITS'(query.radius) << fct_pkg::NORM_FRAC_BITS;
         end
         default: begin
            bias = '0;
         end
      endcase
      offset_in = (fct_pkg::DIST_BITS'(plane.w) <<< fct_pkg::NORM_FRAC_BITS) + bias;
   end

   always_ff @(posedge clock) begin
      corner_x_ff <= corner_x_in;
      corner_y_ff <= corner_y_in;
      corner_z_ff <= corner_z_in;
      offset_ff   <= offset_in;
   end

   assign prod_x_in = fct_pkg::PROD_BITS'(plane.nx) * fct_pkg::PROD_BITS'(corner_x_ff);
   assign prod_y_in = fct_pkg::PROD_BITS'(plane.ny) * fct_pkg::PROD_BITS'(corner_y_ff);
   assign prod_z_in = fct_pkg::PROD_BITS'(plane.nz) * fct_pkg::PROD_BITS'(corner_z_ff);

   always_ff @(posedge clock) begin
      prod_x_ff  <= prod_x_in;
      prod_y_ff  <= prod_y_in;
      prod_z_ff  <= prod_z_in;
      offset2_ff <= offset_ff;
   end

   assign dist_sum = fct_pkg::DIST_BITS'(prod_x_ff) + fct_pkg::DIST_BITS'(prod_y_ff) +
                     fct_pkg::DIST_BITS'(prod_z_ff) + offset2_ff;
   assign cull_in = dist_sum[fct_pkg::DIST_BITS-1] || (dist_sum == '0);

   always_ff @(posedge clock) begin
      cull_ff <= cull_in;
   end

   assign cull = cull_ff;

endmodule

### src/frustum_cull_test.sv
// result: the strobe is registered, taken from the last valid stage bit through strobe_ff
// throughput: one item per cycle; busy stays low, each plane has its own lane of
// three multipliers and the work runs through five register stages
// reset: synchronous, clears the stage valid bits and all six plane registers to zero
`include "frustum_cull_test_defines.svh"

module frustum_cull_test (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   output logic                                      busy,
   input  logic [1:0]                                req_opcode,
   input  logic signed [fct_pkg::COORD_BITS-1:0]     req_first_x,
   input  logic signed [fct_pkg::COORD_BITS-1:0]     req_first_y,
   input  logic signed [fct_pkg::COORD_BITS-1:0]     req_first_z,
   input  logic signed [fct_pkg::COORD_BITS-1:0]     req_second_x,
   input  logic signed [fct_pkg::COORD_BITS-1:0]     req_second_y,
   input  logic signed [fct_pkg::COORD_BITS-1:0]     req_second_z,
   input  logic [fct_pkg::RADIUS_BITS-1:0]           req_sphere_radius,
   output logic                                      rsp_strobe,
   output logic                                      rsp_inside_res,
   input  logic                                      psel,
   input  logic                                      penable,
   input  logic                                      pwrite,
   input  logic [fct_pkg::CSR_ADDR_BITS-1:0]         paddr,
   input  logic [fct_pkg::CSR_DATA_BITS-1:0]         pwdata,
   output logic [fct_pkg::CSR_DATA_BITS-1:0]         prdata,
   output logic                                      pready
);

   fct_pkg::plane_type [fct_pkg::SLOT_COUNT-1:0] planes;
   fct_pkg::query_type                           query_in, query_ff;
   logic [3:0]                                   valid_in, valid_ff;
   logic [2:0]                                   none_in, none_ff;
   logic [fct_pkg::LANE_COUNT-1:0]               cull;
   logic                                         accept;
   logic                                         strobe_in, strobe_ff;
   logic                                         inside_in, inside_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      query_in.opcode   = fct_pkg::op_type'(req_opcode);
      query_in.first_x  = req_first_x;
      query_in.first_y  = req_first_y;
      query_in.first_z  = req_first_z;
      query_in.second_x = req_second_x;
      query_in.second_y = req_second_y;
      query_in.second_z = req_second_z;
      query_in.radius   = req_sphere_radius;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         query_ff <= query_in;
      end
   end

   fct_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .planes  (planes)
   );

   for (genvar i = 0; i < fct_pkg::LANE_COUNT; i++) begin : g_lane
      fct_lane u_lane (
         .clock (clock),
         .query (query_ff),
         .plane (planes[i]),
         .cull  (cull[i])
      );
   end

   assign valid_in  = {valid_ff[2:0], accept};
   assign none_in   = {none_ff[1:0], (query_ff.opcode == fct_pkg::OP_NONE)};
   assign strobe_in = valid_ff[3];
   assign inside_in = valid_ff[3] && !none_ff[2] && !(|cull);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         strobe_ff <= 1'b0;
         inside_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         strobe_ff <= strobe_in;
         inside_ff <= inside_in;
      end
   end

   always_ff @(posedge clock) begin
      none_ff <= none_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_inside_res = inside_ff;

   `FCT_ASSERT(a_item_gives_result, accept |-> ##5 rsp_strobe, "item produced no result")
   `FCT_ASSERT(a_result_has_item, rsp_strobe |-> $past(accept, 5), "result without an item")
   `FCT_ASSERT(a_unused_op_culled, accept && (req_opcode == fct_pkg::OP_NONE) |-> ##5 !rsp_inside_res, "unused opcode passed")
   `FCT_ASSERT_NEVER(a_inside_needs_strobe, rsp_inside_res && !rsp_strobe, "inside flag without strobe")

endmodule
